// File: hdl/salc_pkg.sv
// types and codes shared by the cache front end, engine, top level and checker
// no dependencies
package salc_pkg;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_DATA_W  = 7;
   localparam int AGE_W       = 6;
   localparam logic [AGE_W-1:0] AGE_MAX = 6'd63;

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_PRELOAD = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_TO_CPU     = 3'd0,
      ACT_FROM_CPU   = 3'd1,
      ACT_FILL       = 3'd2,
      ACT_WRITE_BACK = 3'd3,
      ACT_DISCARD    = 3'd4
   } action_type;

   localparam logic [1:0] CSR_BLOCK_WORDS = 2'd0;
   localparam logic [1:0] CSR_SETS        = 2'd1;
   localparam logic [1:0] CSR_WAYS        = 2'd2;

   typedef enum logic {
      JOB_ACCESS,
      JOB_PRELOAD
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         is_write;
      logic [15:0]  address;
      logic [31:0]  wr_word;
   } job_type;

   typedef struct packed {
      logic [3:0] blk_log2;
      logic [3:0] sets_log2;
      logic [8:0] ways;
   } geom_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] start_address;
      logic [4:0]  word_count;
      logic [31:0] read_data;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_EVICT_RD,
      ST_EVICT_WR,
      ST_EVICT_EMIT,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_FILL_EMIT,
      ST_AGE_RD,
      ST_AGE_WR,
      ST_WORD_RD,
      ST_WORD_EMIT
   } state_type;

endpackage

// File: hdl/salc_front.sv
// request front end: accepts words, classifies them and queues them for the engine
// depends on salc_pkg
module salc_front import salc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   clearing,
   input  logic                   job_pop,
   output logic                   job_valid,
   output job_type                job
);

   localparam int QDEPTH = 2;

   job_type    q_ff [QDEPTH];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   opcode_type op;
   job_type    entry;
   logic       push, pop;

   assign op         = opcode_type'(req_tuser);
   assign req_tready = (count_ff != 2'(QDEPTH)) && !clearing;
   assign push       = req_tvalid && req_tready && (op != OP_NONE);
   assign job_valid  = (count_ff != 2'd0);
   assign pop        = job_pop && job_valid;
   assign job        = q_ff[rptr_ff];

   always_comb begin
      entry.kind     = (op == OP_PRELOAD) ? JOB_PRELOAD : JOB_ACCESS;
      entry.is_write = (op == OP_WRITE);
      entry.address  = req_tdata[15:0];
      entry.wr_word  = req_tdata[47:16];
   end

   assign wptr_in  = push ? ~wptr_ff : wptr_ff;
   assign rptr_in  = pop ? ~rptr_ff : rptr_ff;
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= entry;
      end
   end

endmodule

// File: hdl/salc_back.sv
// cache engine: tag scan, eviction, fill, word access and lru ages, with line and
// backing memories; depends on salc_pkg
module salc_back import salc_pkg::*; #(
   parameter int MAX_LINES       = 64,
   parameter int MAX_BLOCK_WORDS = 16,
   parameter int ADDRESS_BITS    = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  geom_type geom,
   input  logic     job_valid,
   input  job_type  job,
   output logic     job_pop,
   output logic     clearing,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   localparam int LIW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int LCW  = $clog2(MAX_LINES + 1);
   localparam int WIW  = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
   localparam int NBW  = $clog2(MAX_BLOCK_WORDS + 1);
   localparam int LWD  = MAX_LINES * MAX_BLOCK_WORDS;
   localparam int LWW  = (LWD > 1) ? $clog2(LWD) : 1;
   localparam int MEMD = 1 << ADDRESS_BITS;
   localparam int AW   = ADDRESS_BITS;

   state_type state_ff, state_in;

   logic [31:0] bm_mem [MEMD];
   logic [31:0] lw_mem [LWD];
   logic [AW-1:0] tag_mem [MAX_LINES];
   logic [AGE_W-1:0] age_mem [MAX_LINES];
   logic [31:0]   bm_q, lw_q;
   logic [AW-1:0] tag_q;
   logic [AGE_W-1:0] age_q;

   logic [MAX_LINES-1:0] valid_ff, dirty_ff;

   logic [AW-1:0]  clr_ff;
   logic           is_write_ff;
   logic [AW-1:0]  addr_ff, tag_ff, fblk_ff, vtag_ff;
   logic [31:0]    wdata_ff;
   logic [WIW-1:0] offset_ff;
   logic [LIW-1:0] set_ff, base_ff, line_ff, inv_ff, vic_ff;
   logic [LCW-1:0] idx_ff;
   logic [NBW-1:0] cnt_ff;
   logic [AGE_W-1:0] best_ff;
   logic [AGE_W:0] limit_ff;
   logic           found_ff, vdirty_ff;
   rsp_type        rsp_ff;
   logic           rsp_valid_ff;

   // geometry of the current access
   logic [LCW-1:0]  ways_n;
   logic [NBW-1:0]  nb;
   logic [AW:0]     one_b;
   logic [AW-1:0]   mask_a, addr_m, set_full, tag_n;
   logic [LIW-1:0]  set_n;
   logic [LIW+9:0]  base_prod;
   logic [LIW-1:0]  scan_line;
   logic [AW+16:0]  vblk_wide;
   logic [AW-1:0]   vblk;
   logic            out_free, last_word, last_way;
   logic            scan_hit;

   // control outputs
   logic            emit;
   rsp_type         emit_rsp;
   logic            bm_we, lw_we, tag_we, age_we;
   logic [AW-1:0]   bm_waddr, bm_raddr;
   logic [31:0]     bm_wdata, lw_wdata;
   logic [LWW-1:0]  lw_waddr, lw_raddr;
   logic [LIW-1:0]  tag_raddr, age_waddr;
   logic [AGE_W-1:0] age_wdata;

   assign ways_n   = LCW'(geom.ways);
   assign nb       = NBW'(1) << geom.blk_log2;
   assign one_b    = (AW+1)'(1) << geom.blk_log2;
   assign mask_a   = AW'(one_b - (AW+1)'(1));
   assign addr_m   = job.address[AW-1:0];
   assign set_full = (addr_m >> geom.blk_log2) & AW'(((AW+1)'(1) << geom.sets_log2) - 1'b1);
   assign set_n    = LIW'(set_full);
   assign tag_n    = addr_m >> (geom.blk_log2 + geom.sets_log2);
   assign base_prod = (LIW+10)'(set_n) * (LIW+10)'(geom.ways);
   assign scan_line = LIW'(base_ff + LIW'(idx_ff));
   assign vblk_wide = ((AW+17)'(vtag_ff) << (geom.sets_log2 + geom.blk_log2))
                    | ((AW+17)'(set_ff) << geom.blk_log2);
   assign vblk      = vblk_wide[AW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_word = (cnt_ff + NBW'(1)) == nb;
   assign last_way  = (idx_ff + LCW'(1)) == ways_n;
   assign scan_hit  = valid_ff[scan_line] && (tag_q == tag_ff);
   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   function automatic logic [15:0] ext_addr(input logic [AW-1:0] a);
      ext_addr = 16'(a);
   endfunction

   function automatic logic [LWW-1:0] lw_index(input logic [LIW-1:0] line,
                                              input logic [WIW-1:0] word);
      lw_index = LWW'(int'(line) * MAX_BLOCK_WORDS + int'(word));
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:      if (clr_ff == AW'(MEMD - 1)) state_in = ST_IDLE;
         ST_IDLE:       if (job_valid && job.kind == JOB_ACCESS) state_in = ST_SCAN_RD;
         ST_SCAN_RD:    state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (scan_hit) state_in = ST_AGE_RD;
            else if (last_way) state_in = ST_DECIDE;
            else state_in = ST_SCAN_RD;
         end
         ST_DECIDE: begin
            if (found_ff) state_in = ST_FILL_RD;
            else if (dirty_ff[vic_ff]) state_in = ST_EVICT_RD;
            else state_in = ST_EVICT_EMIT;
         end
         ST_EVICT_RD:   state_in = ST_EVICT_WR;
         ST_EVICT_WR:   state_in = last_word ? ST_EVICT_EMIT : ST_EVICT_RD;
         ST_EVICT_EMIT: if (out_free) state_in = ST_FILL_RD;
         ST_FILL_RD:    state_in = ST_FILL_WR;
         ST_FILL_WR:    state_in = last_word ? ST_FILL_EMIT : ST_FILL_RD;
         ST_FILL_EMIT:  if (out_free) state_in = ST_AGE_RD;
         ST_AGE_RD:     state_in = ST_AGE_WR;
         ST_AGE_WR:     state_in = last_way ? ST_WORD_RD : ST_AGE_RD;
         ST_WORD_RD:    state_in = ST_WORD_EMIT;
         ST_WORD_EMIT:  if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      job_pop     = 1'b0;
      emit        = 1'b0;
      emit_rsp    = '0;
      bm_we       = 1'b0;
      bm_waddr    = clr_ff;
      bm_wdata    = 32'd0;
      bm_raddr    = AW'(fblk_ff + AW'(cnt_ff));
      lw_we       = 1'b0;
      lw_waddr    = lw_index(line_ff, cnt_ff[WIW-1:0]);
      lw_wdata    = bm_q;
      lw_raddr    = lw_index(line_ff, offset_ff);
      tag_we      = 1'b0;
      tag_raddr   = scan_line;
      age_we      = 1'b0;
      age_waddr   = scan_line;
      age_wdata   = '0;
      case (state_ff)
         ST_CLEAR: begin
            bm_we     = 1'b1;
            age_we    = 1'b1;
            age_waddr = LIW'(clr_ff);
         end
         ST_IDLE: begin
            job_pop = job_valid;
            if (job_valid && job.kind == JOB_PRELOAD) begin
               bm_we    = 1'b1;
               bm_waddr = addr_m;
               bm_wdata = job.wr_word;
            end
         end
         ST_EVICT_RD: begin
            lw_raddr = lw_index(line_ff, cnt_ff[WIW-1:0]);
         end
         ST_EVICT_WR: begin
            bm_we    = 1'b1;
            bm_waddr = AW'(vblk + AW'(cnt_ff));
            bm_wdata = lw_q;
         end
         ST_EVICT_EMIT: begin
            emit = out_free;
            emit_rsp.action        = vdirty_ff ? ACT_WRITE_BACK : ACT_DISCARD;
            emit_rsp.start_address = ext_addr(vblk);
            emit_rsp.word_count    = 5'(nb);
         end
         ST_FILL_WR: begin
            lw_we = 1'b1;
         end
         ST_FILL_EMIT: begin
            emit   = out_free;
            tag_we = out_free;
            emit_rsp.action        = ACT_FILL;
            emit_rsp.start_address = ext_addr(fblk_ff);
            emit_rsp.word_count    = 5'(nb);
         end
         ST_AGE_WR: begin
            if (scan_line == line_ff) begin
               age_we = 1'b1;
            end else if (valid_ff[scan_line] && (AGE_W+1)'(age_q) < limit_ff
                         && age_q < AGE_MAX) begin
               age_we    = 1'b1;
               age_wdata = age_q + AGE_W'(1);
            end
         end
         ST_WORD_EMIT: begin
            emit = out_free;
            emit_rsp.start_address = ext_addr(addr_ff);
            emit_rsp.word_count    = 5'd1;
            emit_rsp.last          = 1'b1;
            if (is_write_ff) begin
               emit_rsp.action = ACT_FROM_CPU;
               lw_we    = out_free;
               lw_waddr = lw_index(line_ff, offset_ff);
               lw_wdata = wdata_ff;
            end else begin
               emit_rsp.action    = ACT_TO_CPU;
               emit_rsp.read_data = lw_q;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= emit_rsp;
   end

   // line state flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
      end else begin
         if (state_ff == ST_FILL_EMIT && out_free) begin
            valid_ff[line_ff] <= 1'b1;
            dirty_ff[line_ff] <= 1'b0;
         end
         if (state_ff == ST_WORD_EMIT && out_free && is_write_ff) dirty_ff[line_ff] <= 1'b1;
      end
   end

   // access registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            is_write_ff <= job.is_write;
            addr_ff     <= addr_m;
            wdata_ff    <= job.wr_word;
            offset_ff   <= WIW'(addr_m & mask_a);
            set_ff      <= set_n;
            tag_ff      <= tag_n;
            fblk_ff     <= addr_m & ~mask_a;
            base_ff     <= LIW'(base_prod);
            idx_ff      <= '0;
            best_ff     <= '0;
            found_ff    <= 1'b0;
         end
         ST_SCAN_CMP: begin
            if (scan_hit) begin
               idx_ff   <= '0;
               line_ff  <= scan_line;
               limit_ff <= (AGE_W+1)'(age_q);
            end else begin
               idx_ff <= idx_ff + LCW'(1);
            end
            if (!valid_ff[scan_line] && !found_ff) begin
               found_ff <= 1'b1;
               inv_ff   <= scan_line;
            end
            if (age_q >= best_ff) begin
               best_ff <= age_q;
               vic_ff  <= scan_line;
               vtag_ff <= tag_q;
            end
         end
         ST_DECIDE: begin
            cnt_ff    <= '0;
            line_ff   <= found_ff ? inv_ff : vic_ff;
            vdirty_ff <= dirty_ff[vic_ff];
         end
         ST_EVICT_WR, ST_FILL_WR: begin
            cnt_ff <= cnt_ff + NBW'(1);
         end
         ST_EVICT_EMIT: begin
            cnt_ff <= '0;
         end
         ST_FILL_EMIT: begin
            idx_ff   <= '0;
            limit_ff <= {1'b1, {AGE_W{1'b0}}};
         end
         ST_AGE_WR: begin
            idx_ff <= idx_ff + LCW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      bm_q <= bm_mem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (lw_we) lw_mem[lw_waddr] <= lw_wdata;
      lw_q <= lw_mem[lw_raddr];
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[line_ff] <= tag_ff;
      tag_q <= tag_mem[tag_raddr];
   end

   always_ff @(posedge clock) begin
      if (age_we) age_mem[age_waddr] <= age_wdata;
      age_q <= age_mem[scan_line];
   end

endmodule

// File: hdl/set_assoc_write_back_lru_cache_core.sv
// top level of the set-associative write-back lru cache: csr registers, geometry
// clamping, front end and engine; depends on salc_pkg, salc_front, salc_back
//
//  channel  dir  handshake              contents
//  req      in   req_tvalid/req_tready  address, store word; tuser opcode
//  rsp      out  rsp_tvalid/rsp_tready  start_address, word_count, read_data; tuser action
//  csr      in   csr_we                 csr_index, csr_wdata
//
// a hit at way k scans ways 0 to k, reading tag and lru age, then updates the age of every
// way and emits the result word. a miss scans every way and decides; with no free line
// a dirty victim is written back word by word or a clean one dropped, with a block record,
// then the line is filled word by word, a fill record sent and ages updated as on a hit.
// a preload writes the backing memory from idle. after reset that memory is cleared with
// req_tready low. a two-word queue and an output register let each side stall on its own.
module set_assoc_write_back_lru_cache_core import salc_pkg::*; #(
   parameter int MAX_LINES       = 64,
   parameter int MAX_BLOCK_WORDS = 16,
   parameter int ADDRESS_BITS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // address, store word
   input  logic [1:0]             req_tuser,   // opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // start_address, word_count, read_data
   output logic [2:0]             rsp_tuser,   // action
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BMAX = $clog2(MAX_BLOCK_WORDS + 1) - 1;
   localparam int SMAX = $clog2(MAX_LINES + 1) - 1;

   logic [2:0] blk_log2_ff, sets_log2_ff;
   logic [6:0] ways_ff;
   geom_type   geom;
   logic [3:0] s_n;
   logic [8:0] cap, w_n;
   logic       clearing, job_valid, job_pop;
   job_type    job;
   rsp_type    rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_log2_ff  <= 3'd2;
         sets_log2_ff <= 3'd1;
         ways_ff      <= 7'd2;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_WORDS: blk_log2_ff  <= csr_wdata[2:0];
            CSR_SETS:        sets_log2_ff <= csr_wdata[2:0];
            CSR_WAYS:        ways_ff      <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s_n = (int'(sets_log2_ff) > SMAX) ? 4'(SMAX) : 4'(sets_log2_ff);
      cap = 9'(MAX_LINES) >> s_n;
      w_n = (ways_ff == 7'd0) ? 9'd1 : 9'(ways_ff);
      if (w_n > cap) w_n = cap;
      geom.blk_log2  = (int'(blk_log2_ff) > BMAX) ? 4'(BMAX) : 4'(blk_log2_ff);
      geom.sets_log2 = s_n;
      geom.ways      = w_n;
   end

   salc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .job_pop    (job_pop),
      .job_valid  (job_valid),
      .job        (job)
   );

   salc_back #(
      .MAX_LINES       (MAX_LINES),
      .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS),
      .ADDRESS_BITS    (ADDRESS_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.action;
   assign rsp_tlast = rsp.last;
   assign rsp_tdata = {3'd0, rsp.read_data, rsp.word_count, rsp.start_address};

endmodule

// File: hdl/salc_checker.sv
// port-level checks for the cache top level, bound into it
// depends on salc_pkg and set_assoc_write_back_lru_cache_core
module salc_checker import salc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ports active during memory clear");

   a_last_is_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[20:16] == 5'd1
         && (rsp_tuser == ACT_TO_CPU || rsp_tuser == ACT_FROM_CPU))
      else $error("final word of an access is not a single-word transfer");

   a_block_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ACT_FILL || rsp_tuser == ACT_WRITE_BACK
         || rsp_tuser == ACT_DISCARD) |-> !rsp_tlast && rsp_tdata[52:21] == 32'd0)
      else $error("block transfer marked last or carrying data");

endmodule

bind set_assoc_write_back_lru_cache_core salc_checker u_salc_checker (.*);
